// File: sv/wmsl_pkg.sv
// Package: shared types, register indexes, command codes and speed helpers for the wheel mixer.
package wmsl_pkg;

  localparam int unsigned NumWheels = 4;
  localparam int unsigned SpeedW    = 8;
  localparam int unsigned SumW      = 10;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;

  typedef logic signed [SpeedW-1:0] speed_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic [NumWheels-1:0]     wheel_mask_t;

  typedef enum logic [2:0] {
    CMD_ARCADE     = 3'd0,
    CMD_TANK       = 3'd1,
    CMD_HOLONOMIC  = 3'd2,
    CMD_RAW_SLEW   = 3'd3,
    CMD_RAW_DIRECT = 3'd4
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SLEW_STEP    = 2'd0,
    REG_REVERSE_MASK = 2'd1,
    REG_ENABLE_MASK  = 2'd2
  } cfg_reg_t;

  localparam speed_t SpeedMax = 8'sd127;

  typedef struct packed {
    logic [2:0] cmd;
    speed_t     forward_speed;
    speed_t     turn_speed;
    speed_t     strafe_speed;
    speed_t     left_speed;
    speed_t     right_speed;
    speed_t     raw_fl;
    speed_t     raw_bl;
    speed_t     raw_fr;
    speed_t     raw_br;
  } in_item_t;

  function automatic sum_t ext_speed(speed_t v);
    return {{(SumW-SpeedW){v[SpeedW-1]}}, v};
  endfunction

  // clamp a mixed sum to +/-127
  function automatic speed_t sat_speed(sum_t v);
    if (v > ext_speed(SpeedMax)) begin
      return SpeedMax;
    end else if (v < -ext_speed(SpeedMax)) begin
      return -SpeedMax;
    end
    return v[SpeedW-1:0];
  endfunction

  // move from last toward target by at most step; zero step passes target
  function automatic speed_t slew_speed(speed_t last, speed_t tgt,
                                        logic [SpeedW-1:0] step);
    logic signed [SpeedW:0] diff;
    logic [SpeedW:0]        gap;
    sum_t                   moved;
    diff  = {last[SpeedW-1], last} - {tgt[SpeedW-1], tgt};
    gap   = diff[SpeedW] ? (~diff + 1'b1) : diff;
    moved = (last > tgt) ? (ext_speed(last) - sum_t'({2'b00, step}))
                         : (ext_speed(last) + sum_t'({2'b00, step}));
    if (step == '0 || gap < {1'b0, step}) begin
      return tgt;
    end
    return moved[SpeedW-1:0];
  endfunction

endpackage

// File: sv/wheel_mixer_slew_limiter_unit.sv
// Top level: four-wheel drive mixer with saturation, slew limiting, reverse and enable masks.
//
// Each accepted item is one drive command (arcade, tank, holonomic, raw slewed
// or raw direct). The command is latched in an input register, then mixed into four
// wheel targets, clamped to +/-127, slew limited against each wheel's stored last
// speed (slew_step of zero passes the target), reversed per reverse_mask and gated
// per enable_mask into the result register. The block takes one item per clock
// while the result register is free or being read; an item leaves the input
// register once the result register is free, and a new item is taken while a result
// waits only if the input register is empty. The stored wheel speeds update as each
// item moves into the result register, so consecutive items see each other's speeds.
// Undefined commands leave the stored speeds alone and return an all-zero result.
// Write the configuration registers only while the block holds no item.
module wheel_mixer_slew_limiter_unit
  import wmsl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             in_cmd,
  input  logic signed [7:0]      in_forward_speed,
  input  logic signed [7:0]      in_turn_speed,
  input  logic signed [7:0]      in_strafe_speed,
  input  logic signed [7:0]      in_left_speed,
  input  logic signed [7:0]      in_right_speed,
  input  logic signed [7:0]      in_raw_front_left,
  input  logic signed [7:0]      in_raw_back_left,
  input  logic signed [7:0]      in_raw_front_right,
  input  logic signed [7:0]      in_raw_back_right,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [7:0]      out_front_left_drive,
  output logic signed [7:0]      out_back_left_drive,
  output logic signed [7:0]      out_front_right_drive,
  output logic signed [7:0]      out_back_right_drive,
  output logic [3:0]             out_driven_mask,
  input  logic                   cfg_we,
  input  logic [CfgIdxW-1:0]     cfg_index,
  input  logic [CfgDataW-1:0]    cfg_data
);

  logic [SpeedW-1:0] slew_step_r;
  wheel_mask_t       reverse_mask_r;
  wheel_mask_t       enable_mask_r;

  logic              in_vld_r;
  in_item_t          in_item_r;
  logic              out_vld_r;
  speed_t            drive_r [NumWheels];
  wheel_mask_t       driven_r;
  speed_t            last_r [NumWheels];

  logic              advance;
  logic              cmd_ok;
  logic              slewed;
  sum_t              f_ext;
  sum_t              t_ext;
  sum_t              s_ext;
  sum_t              mix [NumWheels];
  speed_t            tgt [NumWheels];
  speed_t            last_nxt [NumWheels];
  speed_t            drive_nxt [NumWheels];
  wheel_mask_t       driven_nxt;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  assign f_ext = ext_speed(in_item_r.forward_speed);
  assign t_ext = ext_speed(in_item_r.turn_speed);
  assign s_ext = ext_speed(in_item_r.strafe_speed);

  always_comb begin
    cmd_ok = 1'b1;
    slewed = 1'b1;
    case (in_item_r.cmd)
      CMD_ARCADE: begin
        mix[0] = f_ext - t_ext;
        mix[1] = f_ext - t_ext;
        mix[2] = f_ext + t_ext;
        mix[3] = f_ext + t_ext;
      end
      CMD_TANK: begin
        mix[0] = ext_speed(in_item_r.left_speed);
        mix[1] = ext_speed(in_item_r.left_speed);
        mix[2] = ext_speed(in_item_r.right_speed);
        mix[3] = ext_speed(in_item_r.right_speed);
      end
      CMD_HOLONOMIC: begin
        mix[0] = f_ext + t_ext + s_ext;
        mix[1] = f_ext + t_ext - s_ext;
        mix[2] = f_ext - t_ext - s_ext;
        mix[3] = f_ext - t_ext + s_ext;
      end
      CMD_RAW_SLEW, CMD_RAW_DIRECT: begin
        mix[0] = ext_speed(in_item_r.raw_fl);
        mix[1] = ext_speed(in_item_r.raw_bl);
        mix[2] = ext_speed(in_item_r.raw_fr);
        mix[3] = ext_speed(in_item_r.raw_br);
        slewed = (in_item_r.cmd == CMD_RAW_SLEW);
      end
      default: begin
        for (int w = 0; w < NumWheels; w++) begin
          mix[w] = '0;
        end
        cmd_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int w = 0; w < NumWheels; w++) begin
      tgt[w]      = sat_speed(mix[w]);
      last_nxt[w] = slewed ? slew_speed(last_r[w], tgt[w], slew_step_r) : tgt[w];
      if (!cmd_ok || !enable_mask_r[w]) begin
        drive_nxt[w]  = '0;
        driven_nxt[w] = 1'b0;
      end else begin
        drive_nxt[w]  = reverse_mask_r[w] ? -last_nxt[w] : last_nxt[w];
        driven_nxt[w] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slew_step_r    <= '0;
      reverse_mask_r <= '0;
      enable_mask_r  <= '0;
      in_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
      for (int w = 0; w < NumWheels; w++) begin
        last_r[w] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SLEW_STEP:    slew_step_r    <= cfg_data;
          REG_REVERSE_MASK: reverse_mask_r <= cfg_data[NumWheels-1:0];
          REG_ENABLE_MASK:  enable_mask_r  <= cfg_data[NumWheels-1:0];
          default: ;
        endcase
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (advance && cmd_ok) begin
        for (int w = 0; w < NumWheels; w++) begin
          last_r[w] <= last_nxt[w];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r.cmd           <= in_cmd;
      in_item_r.forward_speed <= in_forward_speed;
      in_item_r.turn_speed    <= in_turn_speed;
      in_item_r.strafe_speed  <= in_strafe_speed;
      in_item_r.left_speed    <= in_left_speed;
      in_item_r.right_speed   <= in_right_speed;
      in_item_r.raw_fl        <= in_raw_front_left;
      in_item_r.raw_bl        <= in_raw_back_left;
      in_item_r.raw_fr        <= in_raw_front_right;
      in_item_r.raw_br        <= in_raw_back_right;
    end
    if (advance) begin
      for (int w = 0; w < NumWheels; w++) begin
        drive_r[w] <= drive_nxt[w];
      end
      driven_r <= driven_nxt;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_front_left_drive  = drive_r[0];
  assign out_back_left_drive   = drive_r[1];
  assign out_front_right_drive = drive_r[2];
  assign out_back_right_drive  = drive_r[3];
  assign out_driven_mask       = driven_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ready)
    else $error("input stalled with empty result register");

  a_undriven_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_driven_mask[0] |-> out_front_left_drive == 8'sd0)
    else $error("undriven wheel carries a speed");

  a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_back_right_drive != -8'sd128 && out_front_right_drive != -8'sd128)
    else $error("drive outside saturation range");

  a_last_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(advance) |-> last_r[1] != -8'sd128 && last_r[2] != -8'sd128)
    else $error("stored speed outside saturation range");

endmodule

// File: tb/wheel_mixer_slew_limiter_unit_tb.sv
// Testbench: directed and random drive commands checked against a wheel mixer predictor or typed expected drives.
module wheel_mixer_slew_limiter_unit_tb
  import wmsl_pkg::*;
();

  localparam logic [2:0] CmdSpare5 = 3'd5;
  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;
  localparam int CycleLimit = 400000;
  localparam int ItemsPerChunk = 70;
  localparam int MaxPrinted = 50;

  typedef struct {
    speed_t      drv[NumWheels];
    wheel_mask_t mask;
  } drive_out_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    cfg_reg_t   reg_idx;
    logic [7:0] reg_val;
    in_item_t   item;
    bit         typed;
    drive_out_t want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [2:0] in_cmd;
  logic signed [7:0] in_forward_speed;
  logic signed [7:0] in_turn_speed;
  logic signed [7:0] in_strafe_speed;
  logic signed [7:0] in_left_speed;
  logic signed [7:0] in_right_speed;
  logic signed [7:0] in_raw_front_left;
  logic signed [7:0] in_raw_back_left;
  logic signed [7:0] in_raw_front_right;
  logic signed [7:0] in_raw_back_right;
  logic out_valid;
  logic out_ready;
  logic signed [7:0] out_front_left_drive;
  logic signed [7:0] out_back_left_drive;
  logic signed [7:0] out_front_right_drive;
  logic signed [7:0] out_back_right_drive;
  logic [3:0] out_driven_mask;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // predictor state and configuration
  int          wheel_speed[NumWheels];
  int          slew_cfg;
  wheel_mask_t reverse_cfg;
  wheel_mask_t enable_cfg;

  drive_out_t pending_drives[$];
  plan_row_t  plan_q[$];
  int         mismatch_count;
  int         cycle_count;
  int         send_idle_pct;
  int         recv_idle_pct;
  string      wheel_name[NumWheels] = '{"front_left", "back_left", "front_right", "back_right"};

  wheel_mixer_slew_limiter_unit uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_cmd               (in_cmd),
    .in_forward_speed     (in_forward_speed),
    .in_turn_speed        (in_turn_speed),
    .in_strafe_speed      (in_strafe_speed),
    .in_left_speed        (in_left_speed),
    .in_right_speed       (in_right_speed),
    .in_raw_front_left    (in_raw_front_left),
    .in_raw_back_left     (in_raw_back_left),
    .in_raw_front_right   (in_raw_front_right),
    .in_raw_back_right    (in_raw_back_right),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_front_left_drive (out_front_left_drive),
    .out_back_left_drive  (out_back_left_drive),
    .out_front_right_drive(out_front_right_drive),
    .out_back_right_drive (out_back_right_drive),
    .out_driven_mask      (out_driven_mask),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic drive_out_t predict_drive(in_item_t it);
    drive_out_t res;
    int tgt[NumWheels];
    int f, t, s, v, gap;
    bit slewed;
    res.mask = '0;
    for (int i = 0; i < NumWheels; i++) res.drv[i] = '0;
    f = int'(it.forward_speed);
    t = int'(it.turn_speed);
    s = int'(it.strafe_speed);
    slewed = 1'b1;
    case (it.cmd)
      CMD_ARCADE: begin
        tgt[0] = f - t; tgt[1] = f - t; tgt[2] = f + t; tgt[3] = f + t;
      end
      CMD_TANK: begin
        tgt[0] = int'(it.left_speed); tgt[1] = int'(it.left_speed);
        tgt[2] = int'(it.right_speed); tgt[3] = int'(it.right_speed);
      end
      CMD_HOLONOMIC: begin
        tgt[0] = f + t + s; tgt[1] = f + t - s;
        tgt[2] = f - t - s; tgt[3] = f - t + s;
      end
      CMD_RAW_SLEW, CMD_RAW_DIRECT: begin
        tgt[0] = int'(it.raw_fl); tgt[1] = int'(it.raw_bl);
        tgt[2] = int'(it.raw_fr); tgt[3] = int'(it.raw_br);
        slewed = (it.cmd == CMD_RAW_SLEW);
      end
      default: return res;
    endcase
    for (int i = 0; i < NumWheels; i++) begin
      v = tgt[i];
      if (v > int'(SpeedMax)) v = int'(SpeedMax);
      else if (v < -int'(SpeedMax)) v = -int'(SpeedMax);
      if (slewed && slew_cfg != 0) begin
        gap = wheel_speed[i] - v;
        if (gap < 0) gap = -gap;
        if (gap >= slew_cfg) begin
          v = (wheel_speed[i] > v) ? wheel_speed[i] - slew_cfg : wheel_speed[i] + slew_cfg;
        end
      end
      wheel_speed[i] = v;
      if (reverse_cfg[i]) v = -v;
      if (enable_cfg[i]) begin
        res.drv[i] = speed_t'(v);
        res.mask[i] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic speed_t rand_speed();
    case ($urandom_range(7))
      0: return speed_t'(-128);
      1: return -SpeedMax;
      2: return SpeedMax;
      3: return speed_t'(0);
      default: return speed_t'($urandom_range(255));
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    speed_t raw[NumWheels];
    int v;
    if ($urandom_range(9) == 0) it.cmd = 3'($urandom_range(CmdSpare7, CmdSpare5));
    else it.cmd = 3'($urandom_range(CMD_RAW_DIRECT, CMD_ARCADE));
    it.forward_speed = rand_speed();
    it.turn_speed = rand_speed();
    it.strafe_speed = rand_speed();
    it.left_speed = rand_speed();
    it.right_speed = rand_speed();
    for (int i = 0; i < NumWheels; i++) raw[i] = rand_speed();
    // aim raw targets at the slew boundary
    if (it.cmd == CMD_RAW_SLEW && $urandom_range(1) == 1) begin
      for (int i = 0; i < NumWheels; i++) begin
        v = wheel_speed[i] + ($urandom_range(1) ? slew_cfg : -slew_cfg)
            + int'($urandom_range(2)) - 1;
        if (v > 127) v = 127;
        if (v < -128) v = -128;
        raw[i] = speed_t'(v);
      end
    end
    it.raw_fl = raw[0];
    it.raw_bl = raw[1];
    it.raw_fr = raw[2];
    it.raw_br = raw[3];
    return it;
  endfunction

  function automatic void plan_item(logic [2:0] cmd, int f, int t, int s, int l, int r,
                                    int fl, int bl, int fr, int br);
    plan_row_t row;
    row.kind = ROW_ITEM;
    row.typed = 1'b0;
    row.item.cmd = cmd;
    row.item.forward_speed = speed_t'(f);
    row.item.turn_speed = speed_t'(t);
    row.item.strafe_speed = speed_t'(s);
    row.item.left_speed = speed_t'(l);
    row.item.right_speed = speed_t'(r);
    row.item.raw_fl = speed_t'(fl);
    row.item.raw_bl = speed_t'(bl);
    row.item.raw_fr = speed_t'(fr);
    row.item.raw_br = speed_t'(br);
    plan_q.push_back(row);
  endfunction

  function automatic void plan_want(int fl, int bl, int fr, int br, wheel_mask_t mask);
    int last;
    last = plan_q.size() - 1;
    plan_q[last].typed = 1'b1;
    plan_q[last].want.drv[0] = speed_t'(fl);
    plan_q[last].want.drv[1] = speed_t'(bl);
    plan_q[last].want.drv[2] = speed_t'(fr);
    plan_q[last].want.drv[3] = speed_t'(br);
    plan_q[last].want.mask = mask;
  endfunction

  function automatic void plan_cfg(cfg_reg_t idx, int val);
    plan_row_t row;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val[7:0];
    plan_q.push_back(row);
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MaxPrinted) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // enter and leave on a falling edge
  task automatic send_item(in_item_t it, bit typed, drive_out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_cmd <= it.cmd;
    in_forward_speed <= it.forward_speed;
    in_turn_speed <= it.turn_speed;
    in_strafe_speed <= it.strafe_speed;
    in_left_speed <= it.left_speed;
    in_right_speed <= it.right_speed;
    in_raw_front_left <= it.raw_fl;
    in_raw_back_left <= it.raw_bl;
    in_raw_front_right <= it.raw_fr;
    in_raw_back_right <= it.raw_br;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed) begin
      void'(predict_drive(it));
      pending_drives.push_back(want);
    end else begin
      pending_drives.push_back(predict_drive(it));
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_SLEW_STEP:    slew_cfg = int'(val);
      REG_REVERSE_MASK: reverse_cfg = val[3:0];
      REG_ENABLE_MASK:  enable_cfg = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    drive_out_t want;
    speed_t got[NumWheels];
    if (rst_n && out_valid && out_ready) begin
      got[0] = out_front_left_drive;
      got[1] = out_back_left_drive;
      got[2] = out_front_right_drive;
      got[3] = out_back_right_drive;
      if (pending_drives.size() == 0) begin
        report_mismatch("result with no item waiting");
      end else begin
        want = pending_drives.pop_front();
        for (int i = 0; i < NumWheels; i++) begin
          if (got[i] !== want.drv[i]) begin
            report_mismatch($sformatf("%s_drive got %0d expected %0d",
                                      wheel_name[i], got[i], want.drv[i]));
          end
        end
        if (out_driven_mask !== want.mask) begin
          report_mismatch($sformatf("driven_mask got %b expected %b",
                                    out_driven_mask, want.mask));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("wheel_mixer_slew_limiter_unit test failed");
      $finish;
    end
  end

  initial begin
    drive_out_t none;
    in_item_t   it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = '0;
    in_forward_speed = '0;
    in_turn_speed = '0;
    in_strafe_speed = '0;
    in_left_speed = '0;
    in_right_speed = '0;
    in_raw_front_left = '0;
    in_raw_back_left = '0;
    in_raw_front_right = '0;
    in_raw_back_right = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatch_count = 0;
    cycle_count = 0;
    slew_cfg = 0;
    reverse_cfg = '0;
    enable_cfg = '0;
    for (int i = 0; i < NumWheels; i++) wheel_speed[i] = 0;
    none.mask = '0;
    for (int i = 0; i < NumWheels; i++) none.drv[i] = '0;
    send_idle_pct = 37;
    recv_idle_pct = 79;

    // no wheel enabled after reset
    plan_item(CMD_ARCADE, 127, 127, 0, 0, 0, 0, 0, 0, 0);
    plan_want(0, 0, 0, 0, 4'h0);
    plan_item(CmdSpare7, -128, -128, -128, -128, -128, -128, -128, -128, -128);
    plan_want(0, 0, 0, 0, 4'h0);
    plan_item(CMD_TANK, 0, 0, 0, -128, 127, 0, 0, 0, 0);
    plan_want(0, 0, 0, 0, 4'h0);
    plan_cfg(REG_ENABLE_MASK, 15);
    plan_item(CMD_RAW_DIRECT, 0, 0, 0, 0, 0, 127, -127, -128, 0);
    plan_want(127, -127, -127, 0, 4'hF);
    plan_cfg(REG_REVERSE_MASK, 10);
    plan_item(CMD_RAW_DIRECT, 0, 0, 0, 0, 0, -128, -128, 127, 127);
    plan_want(-127, 127, 127, -127, 4'hF);
    plan_cfg(REG_REVERSE_MASK, 0);
    plan_cfg(REG_SLEW_STEP, 255);
    plan_item(CMD_RAW_SLEW, 0, 0, 0, 0, 0, 127, 127, -127, -127);
    plan_want(127, 127, -127, -127, 4'hF);
    plan_cfg(REG_SLEW_STEP, 1);
    plan_item(CMD_RAW_SLEW, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    plan_item(CMD_RAW_SLEW, 0, 0, 0, 0, 0, -128, -128, -128, -128);
    plan_item(CMD_TANK, 0, 0, 0, -128, 127, 0, 0, 0, 0);
    plan_item(CMD_ARCADE, -128, -128, 0, 0, 0, 0, 0, 0, 0);
    plan_item(CMD_HOLONOMIC, 127, 127, 127, 0, 0, 0, 0, 0, 0);
    plan_item(CMD_HOLONOMIC, -128, -128, -128, 0, 0, 0, 0, 0, 0);
    plan_item(CMD_HOLONOMIC, 100, -50, 25, 0, 0, 0, 0, 0, 0);
    plan_item(CmdSpare5, 1, 2, 3, 4, 5, 6, 7, 8, 9);
    plan_want(0, 0, 0, 0, 4'h0);
    plan_item(CmdSpare6, 127, 127, 127, 127, 127, 127, 127, 127, 127);
    plan_want(0, 0, 0, 0, 4'h0);
    plan_cfg(REG_SLEW_STEP, 0);
    plan_item(CMD_RAW_SLEW, 0, 0, 0, 0, 0, 127, -128, 64, -1);
    plan_want(127, -127, 64, -1, 4'hF);
    plan_cfg(REG_REVERSE_MASK, 15);
    plan_cfg(REG_ENABLE_MASK, 5);
    plan_cfg(REG_SLEW_STEP, 3);
    plan_item(CMD_ARCADE, 20, -5, 0, 0, 0, 0, 0, 0, 0);
    plan_item(CMD_TANK, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    plan_item(CMD_RAW_SLEW, 0, 0, 0, 0, 0, 3, -3, 2, -4);
    plan_item(CMD_RAW_DIRECT, 0, 0, 0, 0, 0, 1, -1, 2, -2);
    plan_item(CMD_HOLONOMIC, -60, 30, -90, 0, 0, 0, 0, 0, 0);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan_q[k]) begin
      if (plan_q[k].kind == ROW_CFG) begin
        drain();
        write_reg(plan_q[k].reg_idx, plan_q[k].reg_val);
      end else begin
        send_item(plan_q[k].item, plan_q[k].typed, plan_q[k].want);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 79 : 0;
      recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 37 : 0;
      for (int chunk = 0; chunk < 5; chunk++) begin
        drain();
        case ($urandom_range(3))
          0: write_reg(REG_SLEW_STEP, 8'd0);
          1: write_reg(REG_SLEW_STEP, 8'd255);
          2: write_reg(REG_SLEW_STEP, 8'($urandom_range(8, 1)));
          default: write_reg(REG_SLEW_STEP, 8'($urandom_range(255)));
        endcase
        write_reg(REG_REVERSE_MASK, 8'($urandom_range(15)));
        write_reg(REG_ENABLE_MASK, ($urandom_range(3) == 0) ? 8'd15 : 8'($urandom_range(15)));
        for (int n = 0; n < ItemsPerChunk; n++) begin
          it = random_item();
          send_item(it, 1'b0, none);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("wheel_mixer_slew_limiter_unit test passed");
    end else begin
      $display("wheel_mixer_slew_limiter_unit test failed");
    end
    $finish;
  end

endmodule
